// File: hdl/imr_pkg.sv
// Shared types and constants for the interprocessor mailbox register block.
// No dependencies.
package imr_pkg;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_LOAD  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        SZ_BYTE = 2'd0,
        SZ_HALF = 2'd1,
        SZ_WORD = 2'd2,
        SZ_WIDE = 2'd3
    } size_t;

    localparam logic [3:0] SEL_MAIL_M2S   = 4'h0;
    localparam logic [3:0] SEL_MAIL_S2M   = 4'h1;
    localparam logic [3:0] SEL_FLAGS_MAIN = 4'h2;
    localparam logic [3:0] SEL_FLAGS_SUB  = 4'h3;
    localparam logic [3:0] SEL_CTRL       = 4'h4;
    localparam logic [3:0] SEL_ZERO       = 4'h6;

    localparam logic [31:0] CTRL_READ_OR   = 32'hF000_0002;
    localparam logic [15:0] CTRL_HALF_OR   = 16'h0002;
    localparam logic [31:0] CTRL_MODE_MASK = 32'h0000_F000;
    localparam logic [31:0] CTRL_MODE_SET  = 32'h0000_2000;
    localparam logic [31:0] CTRL_TGL_MASK  = 32'h0000_00F0;
    localparam logic [31:0] CTRL_MODE_TRIG = 32'h0000_00A0;

    localparam int BACKING_WORDS_DEF = 64;

    typedef struct packed {
        logic [31:0] mail_m2s;
        logic [31:0] mail_s2m;
        logic [31:0] flags_main;
        logic [31:0] flags_sub;
        logic [31:0] ctrl;
    } regs_t;

endpackage

// File: hdl/imr_store.sv
// Backing store: one write port, one registered read port with write bypass.
// Per-entry valid bits make unwritten entries read as zero after reset.
module imr_store #(
    parameter int WORDS = 64,
    parameter int IDX_W = 6
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_idx,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  logic [31:0]      wr_data,
    output logic [31:0]      rd_data
);
    logic [31:0]      mem [WORDS];
    logic [WORDS-1:0] valid_reg;
    logic [31:0]      rd_word_reg;
    logic             rd_valid_reg;
    logic             hit;

    assign hit = wr_en && (wr_idx == rd_idx);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en) begin
            rd_word_reg <= hit ? wr_data : mem[rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_idx] || hit;
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : 32'd0;

endmodule

// File: hdl/imr_core.sv
// Access decode: read mux, register updates and backing store merge for one beat.
// Depends on imr_pkg.
module imr_core (
    input  imr_pkg::op_t   op,
    input  logic [7:0]     addr_offset,
    input  imr_pkg::size_t access_size,
    input  logic [31:0]    write_data,
    input  imr_pkg::regs_t regs,
    input  logic [31:0]    st_word,
    output imr_pkg::regs_t regs_next,
    output logic           st_we,
    output logic [31:0]    st_wdata,
    output logic [31:0]    read_data
);
    import imr_pkg::*;

    logic [3:0]  sel;
    logic [15:0] st_half;
    logic [31:0] ctl_half_upd;
    logic [31:0] ctl_word_upd;

    function automatic logic [31:0] ctrl_update(input logic [31:0] ctl, input logic [31:0] d);
        logic [31:0] m;
        logic [31:0] c;
        m = d & CTRL_TGL_MASK;
        c = ctl;
        if ((d & CTRL_MODE_TRIG) != 32'd0) begin
            c = (c & ~CTRL_MODE_MASK) | CTRL_MODE_SET;
        end
        if ((c & m) != 32'd0) begin
            c = c & ~m;
        end else begin
            c = c | m;
        end
        return c;
    endfunction

    assign sel          = addr_offset[7:4];
    assign st_half      = addr_offset[1] ? st_word[31:16] : st_word[15:0];
    assign ctl_half_upd = ctrl_update({16'd0, regs.ctrl[15:0]}, {16'd0, write_data[15:0]});
    assign ctl_word_upd = ctrl_update(regs.ctrl, write_data);

    always_comb begin
        regs_next = regs;
        st_we     = 1'b0;
        st_wdata  = st_word;
        read_data = 32'd0;
        case (op)
            OP_READ: begin
                if (access_size == SZ_HALF) begin
                    case (sel)
                        SEL_MAIL_M2S: read_data = {16'd0, regs.mail_m2s[15:0]};
                        SEL_MAIL_S2M: read_data = {16'd0, regs.mail_s2m[15:0]};
                        SEL_CTRL:     read_data = {16'd0, regs.ctrl[15:0] | CTRL_HALF_OR};
                        SEL_ZERO:     read_data = 32'd0;
                        default:      read_data = {16'd0, st_half};
                    endcase
                end else if (access_size != SZ_BYTE) begin
                    case (sel)
                        SEL_MAIL_M2S:   read_data = regs.mail_m2s;
                        SEL_MAIL_S2M:   read_data = regs.mail_s2m;
                        SEL_FLAGS_MAIN: read_data = regs.flags_main;
                        SEL_FLAGS_SUB:  read_data = regs.flags_sub;
                        SEL_CTRL:       read_data = regs.ctrl | CTRL_READ_OR;
                        SEL_ZERO:       read_data = 32'd0;
                        default:        read_data = st_word;
                    endcase
                end
            end
            OP_WRITE: begin
                case (access_size)
                    SZ_BYTE: begin
                        st_we = 1'b1;
                        st_wdata[{addr_offset[1:0], 3'b000} +: 8] = write_data[7:0];
                    end
                    SZ_HALF: begin
                        case (sel)
                            SEL_MAIL_S2M: regs_next.mail_s2m[15:0] = write_data[15:0];
                            SEL_CTRL:     regs_next.ctrl[15:0] = ctl_half_upd[15:0];
                            SEL_ZERO:     ;
                            default: begin
                                st_we = 1'b1;
                                st_wdata[{addr_offset[1], 4'b0000} +: 16] = write_data[15:0];
                            end
                        endcase
                    end
                    default: begin
                        case (sel)
                            SEL_MAIL_S2M:   regs_next.mail_s2m = write_data;
                            SEL_FLAGS_MAIN: regs_next.flags_main = regs.flags_main & ~write_data;
                            SEL_FLAGS_SUB:  regs_next.flags_sub = regs.flags_sub | write_data;
                            SEL_CTRL:       regs_next.ctrl = ctl_word_upd;
                            SEL_ZERO:       ;
                            default: begin
                                st_we    = 1'b1;
                                st_wdata = write_data;
                            end
                        endcase
                    end
                endcase
            end
            OP_LOAD: begin
                case (sel)
                    SEL_MAIL_M2S:   regs_next.mail_m2s = write_data;
                    SEL_MAIL_S2M:   regs_next.mail_s2m = write_data;
                    SEL_FLAGS_MAIN: regs_next.flags_main = write_data;
                    SEL_FLAGS_SUB:  regs_next.flags_sub = write_data;
                    SEL_CTRL:       regs_next.ctrl = write_data;
                    default:        ;
                endcase
            end
            default: ;
        endcase
    end

endmodule

// File: hdl/interprocessor_mailbox_registers.sv
// Interprocessor mailbox register block, sub processor side.
// Depends on imr_pkg, imr_store and imr_core.
//
// Usage:
//   Each input beat on s_ is one bus access (read, write, partner load or no-op)
//   and produces exactly one result beat on m_ carrying the read data (zero for
//   anything but a half-word, word or wide read).
//   Flow: an accepted beat is latched into the access stage; its result is
//   loaded into the output register once the output is free, which raises
//   m_tvalid; the result is then held until it is taken.
//   Throughput: one beat per cycle unless stalled. The backing store is read
//   at acceptance (registered read with bypass of the write retiring in the
//   same cycle) and written when the access stage hands its result to the
//   output register.
//   Reset: mailbox, flag and control words clear; backing store entries read as
//   zero until written, through per-entry valid bits cleared at once. No
//   clearing pass; s_tready is high from the first cycle after reset.
//   Stall: when m_tready is low the output register holds, the access stage
//   fills and holds, and s_tready drops until the output beat is taken.
module interprocessor_mailbox_registers #(
    parameter int BACKING_WORDS = imr_pkg::BACKING_WORDS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // op[1:0], addr_offset[9:2], access_size[11:10],
                                  // write_data[43:12], zero fill[47:44]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata   // read_data[31:0]
);
    import imr_pkg::*;

    localparam int IDX_W = $clog2(BACKING_WORDS);

    logic        s1_valid_reg;
    op_t         s1_op_reg;
    logic [7:0]  s1_off_reg;
    size_t       s1_size_reg;
    logic [31:0] s1_data_reg;
    logic        m_valid_reg;
    logic [31:0] m_data_reg;
    regs_t       regs_reg;
    regs_t       regs_next;

    logic        accept;
    logic        fire;
    logic [7:0]  in_off;
    logic [31:0] st_word;
    logic        st_we;
    logic [31:0] st_wdata;
    logic [31:0] read_data;

    assign in_off   = s_tdata[9:2];
    assign fire     = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || fire;
    assign accept   = s_tvalid && s_tready;

    imr_store #(
        .WORDS (BACKING_WORDS),
        .IDX_W (IDX_W)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_idx  (in_off[2 +: IDX_W]),
        .wr_en   (fire && st_we),
        .wr_idx  (s1_off_reg[2 +: IDX_W]),
        .wr_data (st_wdata),
        .rd_data (st_word)
    );

    imr_core u_core (
        .op          (s1_op_reg),
        .addr_offset (s1_off_reg),
        .access_size (s1_size_reg),
        .write_data  (s1_data_reg),
        .regs        (regs_reg),
        .st_word     (st_word),
        .regs_next   (regs_next),
        .st_we       (st_we),
        .st_wdata    (st_wdata),
        .read_data   (read_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            regs_reg     <= '0;
        end else begin
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (fire) begin
                s1_valid_reg <= 1'b0;
            end
            if (fire) begin
                m_valid_reg <= 1'b1;
                regs_reg    <= regs_next;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_op_reg   <= op_t'(s_tdata[1:0]);
            s1_off_reg  <= in_off;
            s1_size_reg <= size_t'(s_tdata[11:10]);
            s1_data_reg <= s_tdata[43:12];
        end
        if (fire) begin
            m_data_reg <= read_data;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !s1_valid_reg && !m_valid_reg)
        else $error("pipeline not empty after reset");

    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !fire |=> s1_valid_reg && $stable(s1_data_reg))
        else $error("access stage lost a stalled beat");

    a_zero_reg: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && s1_off_reg[7:4] == SEL_ZERO |=> m_tdata == 32'd0)
        else $error("zero register returned nonzero data");

    a_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && s1_op_reg != OP_READ |=> m_tdata == 32'd0)
        else $error("non-read access returned data");
`endif

endmodule

// File: verif/imr_scoreboard_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the interprocessor mailbox register block: predicts the read data of each access.
// Depends on imr_pkg for the access codes, register selects and control constants.
package imr_scoreboard_pkg;

    import imr_pkg::*;

    class mailbox_scoreboard;

        logic [31:0] mail_m2s;
        logic [31:0] mail_s2m;
        logic [31:0] flags_main;
        logic [31:0] flags_sub;
        logic [31:0] ctrl;
        logic [31:0] store [64];
        logic [31:0] read_data_q [$];

        int mismatches;
        int results_checked;
        int reads;
        int writes;
        int loads;
        int nops;

        function void clear_state();
            mail_m2s   = '0;
            mail_s2m   = '0;
            flags_main = '0;
            flags_sub  = '0;
            ctrl       = '0;
            foreach (store[i]) store[i] = '0;
            read_data_q.delete();
            mismatches      = 0;
            results_checked = 0;
            reads  = 0;
            writes = 0;
            loads  = 0;
            nops   = 0;
        endfunction

        function logic [31:0] toggle_control(logic [31:0] cur, logic [31:0] data);
            logic [31:0] m;
            logic [31:0] nxt;
            m   = data & CTRL_TGL_MASK;
            nxt = cur;
            if ((data & CTRL_MODE_TRIG) != '0) nxt = (nxt & ~CTRL_MODE_MASK) | CTRL_MODE_SET;
            if ((nxt & m) != '0) nxt = nxt & ~m;
            else nxt = nxt | m;
            return nxt;
        endfunction

        function int pending();
            return read_data_q.size();
        endfunction

        function void note_access(op_t op, logic [7:0] off, size_t sz, logic [31:0] data);
            logic [3:0]  sel;
            logic [5:0]  idx;
            logic [31:0] word;
            logic [31:0] rd;
            logic [31:0] half_ctl;
            sel  = off[7:4];
            idx  = off[7:2];
            word = store[idx];
            rd   = '0;
            case (op)
                OP_READ: begin
                    reads++;
                    if (sz == SZ_HALF) begin
                        case (sel)
                            SEL_MAIL_M2S: rd = {16'h0, mail_m2s[15:0]};
                            SEL_MAIL_S2M: rd = {16'h0, mail_s2m[15:0]};
                            SEL_CTRL:     rd = {16'h0, ctrl[15:0] | CTRL_HALF_OR};
                            SEL_ZERO:     rd = '0;
                            default:      rd = off[1] ? {16'h0, word[31:16]} : {16'h0, word[15:0]};
                        endcase
                    end else if (sz != SZ_BYTE) begin
                        case (sel)
                            SEL_MAIL_M2S:   rd = mail_m2s;
                            SEL_MAIL_S2M:   rd = mail_s2m;
                            SEL_FLAGS_MAIN: rd = flags_main;
                            SEL_FLAGS_SUB:  rd = flags_sub;
                            SEL_CTRL:       rd = ctrl | CTRL_READ_OR;
                            SEL_ZERO:       rd = '0;
                            default:        rd = word;
                        endcase
                    end
                end
                OP_WRITE: begin
                    writes++;
                    if (sz == SZ_BYTE) begin
                        store[idx][{off[1:0], 3'b000} +: 8] = data[7:0];
                    end else if (sz == SZ_HALF) begin
                        case (sel)
                            SEL_MAIL_S2M: mail_s2m[15:0] = data[15:0];
                            SEL_CTRL: begin
                                half_ctl   = toggle_control({16'h0, ctrl[15:0]}, {16'h0, data[15:0]});
                                ctrl[15:0] = half_ctl[15:0];
                            end
                            SEL_ZERO: ;
                            default: store[idx][{off[1], 4'b0000} +: 16] = data[15:0];
                        endcase
                    end else begin
                        case (sel)
                            SEL_MAIL_S2M:   mail_s2m = data;
                            SEL_FLAGS_MAIN: flags_main = flags_main & ~data;
                            SEL_FLAGS_SUB:  flags_sub = flags_sub | data;
                            SEL_CTRL:       ctrl = toggle_control(ctrl, data);
                            SEL_ZERO: ;
                            default:        store[idx] = data;
                        endcase
                    end
                end
                OP_LOAD: begin
                    loads++;
                    case (sel)
                        SEL_MAIL_M2S:   mail_m2s = data;
                        SEL_MAIL_S2M:   mail_s2m = data;
                        SEL_FLAGS_MAIN: flags_main = data;
                        SEL_FLAGS_SUB:  flags_sub = data;
                        SEL_CTRL:       ctrl = data;
                        default: ;
                    endcase
                end
                default: nops++;
            endcase
            read_data_q.push_back(rd);
        endfunction

        function void check_result(logic [31:0] got);
            logic [31:0] want;
            if (read_data_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result beat, read_data 0x%08h", $realtime, got);
                return;
            end
            want = read_data_q.pop_front();
            results_checked++;
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: read_data expected 0x%08h, got 0x%08h",
                             $realtime, want, got);
            end
        endfunction

    endclass

endpackage

// File: verif/tb_interprocessor_mailbox_registers.sv
`timescale 1ns / 100ps
// Testbench for interprocessor_mailbox_registers: directed and random bus accesses with
// random stalls on both sides. Depends on imr_pkg, imr_scoreboard_pkg and the DUT.
module tb_interprocessor_mailbox_registers;

    import imr_pkg::*;
    import imr_scoreboard_pkg::*;

    localparam int RANDOM_ITEMS    = 900;
    localparam int PRESSURE_AT     = 350;
    localparam int PRESSURE_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 2000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    mailbox_scoreboard sb;
    bit          send_burst;
    int          idle_cycles;
    int          results_taken;
    int          rx_stall;
    bit          rx_burst;
    int          roll;
    op_t         rnd_op;
    size_t       rnd_size;
    logic [7:0]  rnd_off;
    logic [7:0]  last_off;
    logic [31:0] rnd_data;

    interprocessor_mailbox_registers i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    task automatic send_access(op_t op, logic [7:0] off, size_t sz, logic [31:0] data);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'h0, data, sz, off, op};
        do @(posedge aclk); while (!s_tready);
        sb.note_access(op, off, sz, data);
    endtask

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles", $realtime, idle_cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // result side: random stalls, one long hold-off to back up the input
    initial begin
        results_taken = 0;
        rx_burst      = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (results_taken % 30 == 0) rx_burst = ($urandom_range(0, 3) == 0);
            rx_stall = rx_burst ? 0 : $urandom_range(0, 10);
            if (results_taken == PRESSURE_AT) rx_stall = PRESSURE_CYCLES;
            if (rx_stall > 0) begin
                m_tready <= 1'b0;
                repeat (rx_stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tdata);
            results_taken++;
        end
    end

    initial begin
        sb = new;
        sb.clear_state();
        send_burst  = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // reset values, partner loads, flag clear/set, control toggles, zero register
        send_access(OP_READ,  8'h00, SZ_WORD, 32'h0000_0000);
        send_access(OP_READ,  8'h40, SZ_WORD, 32'hFFFF_FFFF);
        send_access(OP_READ,  8'h42, SZ_HALF, 32'h0000_0000);
        send_access(OP_LOAD,  8'h00, SZ_BYTE, 32'hFFFF_FFFF);
        send_access(OP_LOAD,  8'h20, SZ_HALF, 32'hFFFF_FFFF);
        send_access(OP_WRITE, 8'h20, SZ_WORD, 32'h0000_FFFF);
        send_access(OP_READ,  8'h2F, SZ_WORD, 32'h0000_0000);
        send_access(OP_WRITE, 8'h30, SZ_WORD, 32'h8000_0001);
        send_access(OP_WRITE, 8'h40, SZ_WORD, 32'h0000_00A0);
        send_access(OP_WRITE, 8'h44, SZ_HALF, 32'hFFFF_00F0);
        send_access(OP_READ,  8'h4C, SZ_WORD, 32'h0000_0000);
        send_access(OP_LOAD,  8'h40, SZ_WORD, 32'h0000_0000);
        send_access(OP_WRITE, 8'h40, SZ_WORD, 32'h0000_0010);
        send_access(OP_READ,  8'h41, SZ_HALF, 32'h0000_0000);
        send_access(OP_WRITE, 8'h10, SZ_WORD, 32'hDEAD_BEEF);
        send_access(OP_WRITE, 8'h12, SZ_HALF, 32'hFFFF_1234);
        send_access(OP_READ,  8'h10, SZ_HALF, 32'h0000_0000);
        send_access(OP_WRITE, 8'h53, SZ_BYTE, 32'hFFFF_FFAB);
        send_access(OP_READ,  8'h52, SZ_HALF, 32'h0000_0000);
        send_access(OP_READ,  8'h50, SZ_BYTE, 32'h0000_0000);
        send_access(OP_WRITE, 8'h60, SZ_WORD, 32'hFFFF_FFFF);
        send_access(OP_READ,  8'h62, SZ_HALF, 32'h0000_0000);
        send_access(OP_WRITE, 8'hFC, SZ_WIDE, 32'hFFFF_FFFF);
        send_access(OP_READ,  8'hFF, SZ_WIDE, 32'h0000_0000);
        send_access(OP_LOAD,  8'h70, SZ_WORD, 32'h1234_5678);
        send_access(OP_NOP,   8'hFF, SZ_WIDE, 32'hFFFF_FFFF);
        send_access(OP_READ,  8'h70, SZ_WORD, 32'h0000_0000);

        last_off = 8'h00;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) send_burst = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 99);
            if (roll < 35) rnd_op = OP_READ;
            else if (roll < 75) rnd_op = OP_WRITE;
            else if (roll < 92) rnd_op = OP_LOAD;
            else rnd_op = OP_NOP;
            if ($urandom_range(0, 9) < 4) begin
                rnd_off = last_off;
            end else begin
                rnd_off = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 3) != 0) rnd_off[7:4] = 4'($urandom_range(0, 7));
            end
            roll = $urandom_range(0, 99);
            if (roll < 10) rnd_size = SZ_BYTE;
            else if (roll < 45) rnd_size = SZ_HALF;
            else if (roll < 90) rnd_size = SZ_WORD;
            else rnd_size = SZ_WIDE;
            roll = $urandom_range(0, 19);
            if (roll == 0) rnd_data = '0;
            else if (roll == 1) rnd_data = '1;
            else rnd_data = $urandom();
            send_access(rnd_op, rnd_off, rnd_size, rnd_data);
            last_off = rnd_off;
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        $display("Covered %0d reads, %0d writes, %0d partner loads and %0d no-ops,",
                 sb.reads, sb.writes, sb.loads, sb.nops);
        $display("with one long output hold-off; %0d results checked, %0d mismatches.",
                 sb.results_checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
